// ===== hdl/abr_pkg.sv =====
// Shared types, constants and the lux threshold table for the backlight ramp.
// No dependencies; every other file except abr_fifo imports this package.
`default_nettype none

package abr_pkg;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Reset values and mapping constants
  localparam logic [7:0] LEVEL_RESET = 8'd127;
  localparam logic [7:0] GOAL_RESET  = 8'd0;
  localparam logic [7:0] HYST_RESET  = 8'd10;
  localparam int         MAP_OFFSET  = 61;
  localparam int         MAX_TARGET  = 242;
  localparam int         POW_EXP     = 63;

  // Default queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // Input transaction
  typedef struct packed {
    logic        req_type;
    logic [15:0] lux_reading;
    logic        person_present;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] level;
    logic [7:0] target_level;
    logic       ramp_active;
    logic       level_changed;
  } out_item_t;

  // Classified command from front to back
  typedef struct packed {
    logic       is_tick;
    logic [7:0] target;
  } cmd_t;

  // Threshold k: smallest lux with lux^63 >= 10^(61+k); unused slots never match
  typedef logic [255:0][16:0] thr_tab_t;
  typedef logic [1023:0]      big_t;

  // lux^63 by square-and-multiply (63 = 0b111111)
  function automatic big_t pow63(input logic [15:0] x);
    big_t b;
    big_t r;
    b = big_t'(x);
    r = b;
    for (int i = 0; i < 5; i++) begin
      r = r * r;
      r = r * b;
    end
    return r;
  endfunction

  function automatic thr_tab_t build_thr_tab();
    thr_tab_t    tab;
    big_t        p10;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [16:0] mid;
    tab = '0;
    p10 = big_t'(1);
    for (int i = 0; i < MAP_OFFSET + 1; i++) begin
      p10 = p10 * big_t'(10);
    end
    for (int k = 1; k < 256; k++) begin
      if (k <= MAX_TARGET) begin
        // binary search: pow63(lo) < p10 <= pow63(hi)
        lo = 17'd0;
        hi = 17'd65535;
        for (int s = 0; s < 16; s++) begin
          mid = (lo + hi) >> 1;
          if (pow63(mid[15:0]) >= p10) begin
            hi = mid;
          end else begin
            lo = mid;
          end
        end
        tab[k] = hi;
        p10 = p10 * big_t'(10);
      end else begin
        tab[k] = 17'h10000;
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr_tab();

endpackage

`default_nettype wire

// ===== hdl/ambient_backlight_ramp_top.sv =====
// Top level of the ambient light backlight ramp.
// Instantiates abr_front, abr_fifo (twice) and abr_back; uses abr_pkg.
//
//   channel   ports                        accepted when
//   input     push, full, in_data          push && !full
//   result    empty, pop, out_data         pop && !empty
//   config    cfg_we, cfg_wdata            cfg_we
//
// One transaction per cycle sustained while no queue stalls; a result passes
// through the input stage, the command queue and the result queue to out_data.
// The lux mapping is a 242-entry threshold search split over the input edge
// and the input stage. Synchronous reset empties queues, clears control state.
// Each side stalls on its own: a full result queue stops the back end and the
// input side runs on until the command queue fills, then full rises.
`default_nettype none

module ambient_backlight_ramp_top
  import abr_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_data,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  cmd_t      cmd_in, cmd_out;
  logic      cmd_wr, cmd_full, cmd_empty, cmd_pop;
  out_item_t res;
  logic      res_push, res_full;

  abr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_wr   (cmd_wr),
    .cmd_full (cmd_full),
    .cmd      (cmd_in)
  );

  abr_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  abr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  abr_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(out_item_t))
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

`default_nettype wire

// ===== hdl/abr_fifo.sv =====
// Small register-based FIFO used between front and back and on the result side.
// Depends on nothing outside itself.
`default_nettype none

module abr_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CFULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/abr_front.sv =====
// Front end: accepts input transactions and maps lux to a target level.
// Uses abr_pkg for types and the threshold table.
`default_nettype none

module abr_front
  import abr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data,
  output logic          cmd_wr,
  input  wire logic     cmd_full,
  output cmd_t          cmd
);

  logic       s1_v_r, s1_v_nxt;
  in_item_t   s1_item_r;
  logic [3:0] s1_thi_r;
  logic [7:0] coarse;
  logic [7:0] fine;
  logic [7:0] cand_c;
  logic [7:0] cand_f;
  logic       accept;

  assign full   = s1_v_r && cmd_full;
  assign accept = push && !full;
  assign cmd_wr = s1_v_r;

  // coarse search: upper four bits of the target
  always_comb begin
    coarse = '0;
    cand_c = '0;
    for (int b = 7; b >= 4; b--) begin
      cand_c    = coarse;
      cand_c[b] = 1'b1;
      if ({1'b0, in_data.lux_reading} >= THR_TAB[cand_c]) begin
        coarse = cand_c;
      end
    end
  end

  // fine search: lower four bits
  always_comb begin
    fine   = {s1_thi_r, 4'b0000};
    cand_f = '0;
    for (int b = 3; b >= 0; b--) begin
      cand_f    = fine;
      cand_f[b] = 1'b1;
      if ({1'b0, s1_item_r.lux_reading} >= THR_TAB[cand_f]) begin
        fine = cand_f;
      end
    end
  end

  // classify
  always_comb begin
    cmd.is_tick = (s1_item_r.req_type == REQ_TICK);
    cmd.target  = s1_item_r.person_present ? fine : 8'd0;
  end

  // stage valid
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_v_r && !cmd_full) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
      s1_thi_r  <= coarse[7:4];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/abr_back.sv =====
// Back end: holds level and ramp state, executes commands, builds results.
// Uses abr_pkg for types and reset constants.
`default_nettype none

module abr_back
  import abr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       cmd_empty,
  output logic            cmd_pop,
  input  wire cmd_t       cmd,
  input  wire logic       res_full,
  output logic            res_push,
  output out_item_t       res
);

  logic [7:0] thr_r;
  logic [7:0] level_r, level_nxt;
  logic [7:0] goal_r, goal_nxt;
  logic       ramping_r, ramping_nxt;
  logic       step_down_r, step_down_nxt;
  logic [7:0] stepped;
  logic [7:0] diff;
  logic       changed;
  logic       run;

  assign run      = !cmd_empty && !res_full;
  assign cmd_pop  = run;
  assign res_push = run;

  // execute one command
  always_comb begin
    level_nxt     = level_r;
    goal_nxt      = goal_r;
    ramping_nxt   = ramping_r;
    step_down_nxt = step_down_r;
    changed       = 1'b0;
    stepped       = step_down_r ? level_r - 8'd1 : level_r + 8'd1;
    diff          = (cmd.target >= level_r) ? cmd.target - level_r : level_r - cmd.target;
    if (run) begin
      if (cmd.is_tick) begin
        if (ramping_r) begin
          level_nxt = stepped;
          changed   = 1'b1;
          if (stepped == goal_r) begin
            ramping_nxt = 1'b0;
          end
        end
      end else if (!ramping_r) begin
        goal_nxt = cmd.target;
        if (diff != 8'd0 && diff >= thr_r) begin
          ramping_nxt   = 1'b1;
          step_down_nxt = (cmd.target < level_r);
        end
      end
    end
  end

  always_comb begin
    res.level         = level_nxt;
    res.target_level  = goal_nxt;
    res.ramp_active   = ramping_nxt;
    res.level_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= HYST_RESET;
      level_r     <= LEVEL_RESET;
      goal_r      <= GOAL_RESET;
      ramping_r   <= 1'b0;
      step_down_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      level_r     <= level_nxt;
      goal_r      <= goal_nxt;
      ramping_r   <= ramping_nxt;
      step_down_r <= step_down_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/abr_checker.sv =====
// Port-level checks for the backlight ramp, bound to the top level.
// Uses abr_pkg for the result type.
`default_nettype none

module abr_checker
  import abr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data
);

  // reset leaves no result waiting and the input open
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // an active ramp never sits on its target
  a_ramp_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.ramp_active) |-> (out_data.level != out_data.target_level))
    else $error("ramp active with level at target");

  // a step that ends the ramp lands on the target
  a_ramp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.level_changed && !out_data.ramp_active)
      |-> (out_data.level == out_data.target_level))
    else $error("ramp ended away from target");

endmodule

bind ambient_backlight_ramp_top abr_checker u_abr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire
